### design/rau_pkg.sv
// shared constants, types and helper functions of the rational arithmetic unit
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int MAG_W     = 64;
  localparam int CNT_W     = 6;

  // largest magnitude a negative word may hold
  localparam logic [MAG_W-1:0] MAG_LIM = 64'd1 << (WORD_BITS - 1);

  // operation codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_CMP   = 3'd4;
  localparam logic [2:0] OP_SPLIT = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // compare codes
  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // multiplier step indexes
  localparam logic [1:0] MSTEP_0 = 2'd0;
  localparam logic [1:0] MSTEP_1 = 2'd1;
  localparam logic [1:0] MSTEP_2 = 2'd2;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PREP  = 13'b0000000000010,
    S_MUL0  = 13'b0000000000100,
    S_MUL1  = 13'b0000000001000,
    S_MUL2  = 13'b0000000010000,
    S_MUL3  = 13'b0000000100000,
    S_SINIT = 13'b0000001000000,
    S_SDIV  = 13'b0000010000000,
    S_GINIT = 13'b0000100000000,
    S_GCD   = 13'b0001000000000,
    S_DINIT = 13'b0010000000000,
    S_DIV   = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       acc_en;
    logic [1:0] acc_step;
    logic       split_init;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic early;
    logic is_cmp;
    logic is_split;
    logic gcd_done;
    logic div_last;
    logic out_free;
  } stat_t;

  // restoring divider state: quotient register holds the dividend on entry
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] quo;
  } div_t;

  // one restoring division step
  function automatic div_t div_iter(div_t s, logic [MAG_W-1:0] dv);
    logic [MAG_W:0] t;
    div_t           r;
    t = {s.rem, s.quo[MAG_W-1]};
    if (t >= {1'b0, dv}) begin
      t     = t - {1'b0, dv};
      r.quo = {s.quo[MAG_W-2:0], 1'b1};
    end else begin
      r.quo = {s.quo[MAG_W-2:0], 1'b0};
    end
    r.rem = t[MAG_W-1:0];
    return r;
  endfunction

endpackage

### design/rau_ctrl.sv
// controller state machine sequencing multiply, divide, gcd and result phases
module rau_ctrl import rau_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (stat.early) begin
          state_nxt = S_EMIT;
        end else if (stat.is_split) begin
          state_nxt = S_SINIT;
        end else begin
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MSTEP_0;
        state_nxt    = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MSTEP_1;
        cmd.acc_en   = 1'b1;
        cmd.acc_step = MSTEP_0;
        state_nxt    = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MSTEP_2;
        cmd.acc_en   = 1'b1;
        cmd.acc_step = MSTEP_1;
        state_nxt    = S_MUL3;
      end
      S_MUL3: begin
        cmd.acc_en   = 1'b1;
        cmd.acc_step = MSTEP_2;
        state_nxt    = stat.is_cmp ? S_EMIT : S_GINIT;
      end
      S_SINIT: begin
        cmd.split_init = 1'b1;
        state_nxt      = S_SDIV;
      end
      S_SDIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_GINIT;
        end
      end
      S_GINIT: begin
        cmd.gcd_init = 1'b1;
        state_nxt    = S_GCD;
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          state_nxt = S_DINIT;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### design/rau_dp.sv
// datapath: operand registers, multiplier, accumulator, binary gcd, dividers, output register
module rau_dp import rau_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_a_num,
  input  logic [30:0]        in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic [30:0]        in_b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic signed [31:0] out_whole_part,
  output logic [1:0]         out_order,
  output logic [1:0]         out_status
);

  logic [2:0]             op_r;
  logic [31:0]            an_r, bn_r;
  logic [30:0]            ad_r, bd_r;
  logic [MAG_W-1:0]       prod_mag_r;
  logic                   prod_neg_r;
  logic signed [MAG_W:0]  n_r, r_r;
  logic [MAG_W-1:0]       d_r;
  logic                   neg_r, whole_neg_r;
  logic [MAG_W-1:0]       whole_mag_r, mag_r, den_r;
  logic [MAG_W-1:0]       u_r, v_r;
  logic [CNT_W-1:0]       k_r, cnt_r;
  div_t                   da_r, db_r;
  logic [MAG_W-1:0]       dva_r, dvb_r;
  logic                   out_valid_r;
  logic [31:0]            out_num_r, out_whole_r;
  logic [30:0]            out_den_r;
  logic [1:0]             out_order_r, out_status_r;

  logic                   an_neg, bn_neg;
  logic [31:0]            an_mag, bn_mag;
  logic [31:0]            ma, mb;
  logic                   msgn;
  logic signed [MAG_W:0]  ps;
  logic [MAG_W:0]         n_abs;
  logic [MAG_W-1:0]       g;
  logic                   bad_op, divz;
  logic [MAG_W-1:0]       fden;
  logic                   fneg, mag_ok, den_ok, whole_ok;
  logic [31:0]            e_num, e_whole;
  logic [30:0]            e_den;
  logic [1:0]             e_order, e_status;

  // operand magnitudes and signs
  assign an_neg = an_r[31];
  assign bn_neg = bn_r[31];
  assign an_mag = an_neg ? (~an_r + 32'd1) : an_r;
  assign bn_mag = bn_neg ? (~bn_r + 32'd1) : bn_r;

  // early exits
  assign bad_op = (op_r > OP_SPLIT);
  assign divz   = (ad_r == '0) || ((op_r != OP_SPLIT) && (bd_r == '0)) ||
                  ((op_r == OP_DIV) && (bn_r == '0));

  // multiplier operand selection per step
  always_comb begin
    ma   = an_mag;
    mb   = {1'b0, bd_r};
    msgn = 1'b0;
    case (cmd.mul_step)
      MSTEP_0: begin
        if (op_r == OP_MUL) begin
          mb   = bn_mag;
          msgn = an_neg ^ bn_neg;
        end else begin
          msgn = an_neg ^ ((op_r == OP_DIV) && bn_neg);
        end
      end
      MSTEP_1: begin
        if (op_r == OP_MUL) begin
          ma = {1'b0, ad_r};
        end else if (op_r == OP_DIV) begin
          ma = {1'b0, ad_r};
          mb = bn_mag;
        end else begin
          ma   = bn_mag;
          mb   = {1'b0, ad_r};
          msgn = bn_neg;
        end
      end
      default: begin
        ma = {1'b0, ad_r};
        if (op_r == OP_DIV) begin
          mb = bn_mag;
        end
      end
    endcase
  end

  // signed view of the registered product
  assign ps    = prod_neg_r ? ($signed({1'b0, 64'd0}) - $signed({1'b0, prod_mag_r}))
                            : $signed({1'b0, prod_mag_r});
  assign n_abs = n_r[MAG_W] ? (~n_r + 65'd1) : n_r;

  // gcd result once one operand reached zero
  assign g = (u_r | v_r) << k_r;

  // operand capture, products, accumulation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      an_r <= in_a_num;
      ad_r <= in_a_den;
      bn_r <= in_b_num;
      bd_r <= in_b_den;
    end
    if (cmd.mul_en) begin
      prod_mag_r <= ma * mb;
      prod_neg_r <= msgn;
    end
    if (cmd.acc_en) begin
      case (cmd.acc_step)
        MSTEP_0: n_r <= ps;
        MSTEP_1: begin
          case (op_r)
            OP_ADD:  n_r <= n_r + ps;
            OP_SUB:  n_r <= n_r - ps;
            OP_CMP:  r_r <= ps;
            default: d_r <= prod_mag_r;
          endcase
        end
        default: begin
          if ((op_r == OP_ADD) || (op_r == OP_SUB) || (op_r == OP_CMP)) begin
            d_r <= prod_mag_r;
          end
        end
      endcase
    end
  end

  // binary gcd
  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      k_r <= '0;
      if (op_r == OP_SPLIT) begin
        neg_r       <= an_neg;
        whole_neg_r <= an_neg;
        whole_mag_r <= da_r.quo;
        mag_r       <= da_r.rem;
        den_r       <= {33'd0, ad_r};
        u_r         <= da_r.rem;
        v_r         <= {33'd0, ad_r};
      end else begin
        neg_r       <= n_r[MAG_W];
        whole_neg_r <= 1'b0;
        whole_mag_r <= '0;
        mag_r       <= n_abs[MAG_W-1:0];
        den_r       <= d_r;
        u_r         <= n_abs[MAG_W-1:0];
        v_r         <= d_r;
      end
    end else if (cmd.gcd_step) begin
      if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r >= v_r) begin
        u_r <= u_r - v_r;
      end else begin
        v_r <= v_r - u_r;
      end
    end
  end

  // two restoring dividers, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.split_init) begin
      da_r  <= '{rem: '0, quo: {32'd0, an_mag}};
      dva_r <= {33'd0, ad_r};
      cnt_r <= '0;
    end else if (cmd.div_init) begin
      da_r  <= '{rem: '0, quo: mag_r};
      db_r  <= '{rem: '0, quo: den_r};
      dva_r <= g;
      dvb_r <= g;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      da_r  <= div_iter(da_r, dva_r);
      db_r  <= div_iter(db_r, dvb_r);
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // result formation and range checks
  always_comb begin
    e_num    = '0;
    e_den    = 31'd1;
    e_whole  = '0;
    e_order  = ORD_LT;
    e_status = ST_OK;
    fneg     = neg_r && (da_r.quo != '0);
    fden     = (da_r.quo == '0) ? 64'd1 : db_r.quo;
    mag_ok   = fneg ? (da_r.quo <= MAG_LIM) : (da_r.quo < MAG_LIM);
    den_ok   = (fden < MAG_LIM);
    whole_ok = whole_neg_r ? (whole_mag_r <= MAG_LIM) : (whole_mag_r < MAG_LIM);
    if (bad_op) begin
      e_status = ST_OK;
    end else if (divz) begin
      e_status = ST_DIVZ;
    end else if (op_r == OP_CMP) begin
      if (n_r < r_r) begin
        e_order = ORD_LT;
      end else if (n_r == r_r) begin
        e_order = ORD_EQ;
      end else begin
        e_order = ORD_GT;
      end
    end else if (mag_ok && den_ok && whole_ok) begin
      e_num   = fneg ? (~da_r.quo[31:0] + 32'd1) : da_r.quo[31:0];
      e_den   = fden[30:0];
      e_whole = whole_neg_r ? (~whole_mag_r[31:0] + 32'd1) : whole_mag_r[31:0];
    end else begin
      e_status = ST_OVF;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_num_r    <= e_num;
      out_den_r    <= e_den;
      out_whole_r  <= e_whole;
      out_order_r  <= e_order;
      out_status_r <= e_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_res_num    = out_num_r;
  assign out_res_den    = out_den_r;
  assign out_whole_part = out_whole_r;
  assign out_order      = out_order_r;
  assign out_status     = out_status_r;

  // status to controller
  assign stat.early    = bad_op || divz;
  assign stat.is_cmp   = (op_r == OP_CMP);
  assign stat.is_split = (op_r == OP_SPLIT);
  assign stat.gcd_done = (u_r == '0) || (v_r == '0);
  assign stat.div_last = (cnt_r == {CNT_W{1'b1}});
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

### design/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: one transaction at a time. Add, subtract, multiply and divide
// run a multiplier phase, a binary gcd (one subtract or shift per cycle over 64-bit
// magnitudes) and a restoring division to reduce the result; split replaces the
// multiplier phase by a division of the numerator. Compare runs only the multiplier
// phase, and error or unused codes go straight to the result. A finished result waits
// in the output register while the next transaction is taken.
module rational_arithmetic_unit_top import rau_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_a_num,
  input  logic [30:0]        in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic [30:0]        in_b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic signed [31:0] out_whole_part,
  output logic [1:0]         out_order,
  output logic [1:0]         out_status
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and result register
  rau_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_op          (in_op),
    .in_a_num       (in_a_num),
    .in_a_den       (in_a_den),
    .in_b_num       (in_b_num),
    .in_b_den       (in_b_den),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_res_num    (out_res_num),
    .out_res_den    (out_res_den),
    .out_whole_part (out_whole_part),
    .out_order      (out_order),
    .out_status     (out_status)
  );

endmodule

### design/rau_chk.sv
// port-level checker for the rational arithmetic unit and its bind
module rau_chk import rau_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [2:0]         in_op,
  input logic signed [31:0] in_a_num,
  input logic [30:0]        in_a_den,
  input logic signed [31:0] in_b_num,
  input logic [30:0]        in_b_den,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_res_num,
  input logic [30:0]        out_res_den,
  input logic signed [31:0] out_whole_part,
  input logic [1:0]         out_order,
  input logic [1:0]         out_status
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_num) && $stable(out_res_den))
    else $error("result changed while stalled");

  // error results carry the neutral fraction
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_res_num == '0) && (out_res_den == 31'd1) && (out_whole_part == '0) &&
      (out_order == ORD_LT))
    else $error("error result not cleared");

  // denominator never zero
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res_den != '0))
    else $error("zero result denominator");

  // one transaction in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

bind rational_arithmetic_unit_top rau_chk u_rau_chk (.*);

### test/rational_arithmetic_unit_top_test.sv
// testbench of the rational arithmetic unit: random and directed fractions against a predictor
`timescale 1ns / 100ps

module rational_arithmetic_unit_top_test;
  import rau_pkg::*;

  typedef struct {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic signed [31:0] whole_part;
    logic [1:0]         order;
    logic [1:0]         status;
  } frac_res_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_op;
  logic signed [31:0] in_a_num;
  logic [30:0]        in_a_den;
  logic signed [31:0] in_b_num;
  logic [30:0]        in_b_den;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_res_num;
  logic [30:0]        out_res_den;
  logic signed [31:0] out_whole_part;
  logic [1:0]         out_order;
  logic [1:0]         out_status;

  frac_res_t expected_q[$];
  int        mismatch_cnt;
  int        result_cnt;
  int        sent_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;

  rational_arithmetic_unit_top u_dut (.*);

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // euclidean gcd over magnitudes
  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return (x != 0) ? x : 64'd1;
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic frac_res_t error_res(logic [1:0] code);
    frac_res_t r;
    r.res_num    = '0;
    r.res_den    = 31'd1;
    r.whole_part = '0;
    r.order      = ORD_LT;
    r.status     = code;
    return r;
  endfunction

  // reduce sign/magnitude over den and range check
  function automatic frac_res_t reduce_frac(logic neg, logic [63:0] mag, logic [63:0] den,
                                            logic signed [63:0] whole);
    frac_res_t   r;
    logic [63:0] g;
    logic [63:0] wmag;
    logic        wneg;
    logic        ok;
    g    = gcd64(mag, den);
    mag  = mag / g;
    den  = den / g;
    wneg = whole < 0;
    wmag = mag64(whole);
    if (mag == 0) begin
      neg = 1'b0;
      den = 64'd1;
    end
    ok = (neg ? mag <= MAG_LIM : mag < MAG_LIM) && den < MAG_LIM &&
         (wneg ? wmag <= MAG_LIM : wmag < MAG_LIM);
    if (!ok) return error_res(ST_OVF);
    r.res_num    = neg ? -mag[31:0] : mag[31:0];
    r.res_den    = den[30:0];
    r.whole_part = wneg ? -wmag[31:0] : wmag[31:0];
    r.order      = ORD_LT;
    r.status     = ST_OK;
    return r;
  endfunction

  // expected outcome of one fraction operation
  function automatic frac_res_t predict_fraction(logic [2:0] op, logic signed [31:0] an,
                                                 logic [30:0] ad, logic signed [31:0] bn,
                                                 logic [30:0] bd);
    logic signed [63:0] a_n, a_d, b_n, b_d, n, l, rr, w, rem;
    logic [63:0]        d;
    frac_res_t          r;
    a_n = an;
    b_n = bn;
    a_d = {33'd0, ad};
    b_d = {33'd0, bd};
    if (op > OP_SPLIT) return error_res(ST_OK);
    if (ad == 0 || (op != OP_SPLIT && bd == 0)) return error_res(ST_DIVZ);
    d = a_d * b_d;
    case (op)
      OP_ADD: n = a_n * b_d + b_n * a_d;
      OP_SUB: n = a_n * b_d - b_n * a_d;
      OP_MUL: n = a_n * b_n;
      OP_DIV: begin
        if (bn == 0) return error_res(ST_DIVZ);
        n = a_n * b_d;
        if (bn < 0) n = -n;
        d = a_d * mag64(b_n);
      end
      OP_CMP: begin
        l  = a_n * b_d;
        rr = b_n * a_d;
        r  = error_res(ST_OK);
        r.order = (l < rr) ? ORD_LT : ((l == rr) ? ORD_EQ : ORD_GT);
        return r;
      end
      default: begin
        w   = a_n / a_d;
        rem = a_n - w * a_d;
        return reduce_frac(rem < 0, mag64(rem), a_d, w);
      end
    endcase
    return reduce_frac(n < 0, mag64(n), d, 64'sd0);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", result_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // send one transaction and queue its expectation
  task automatic send_fraction(logic [2:0] op, logic signed [31:0] an, logic [30:0] ad,
                               logic signed [31:0] bn, logic [30:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_fraction(op, an, ad, bn, bd));
    sent_cnt++;
    @(negedge clk);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    frac_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_res_num, 0);
      end else begin
        e = expected_q.pop_front();
        if (out_res_num !== e.res_num) report_mismatch("res_num", out_res_num, e.res_num);
        if (out_res_den !== e.res_den) report_mismatch("res_den", out_res_den, e.res_den);
        if (out_whole_part !== e.whole_part)
          report_mismatch("whole_part", out_whole_part, e.whole_part);
        if (out_order !== e.order) report_mismatch("order", out_order, e.order);
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
      end
      result_cnt++;
    end
  end

  function automatic logic [31:0] rand_num();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(40)) - 20;
      2: return $signed($urandom_range(2000)) - 1000;
      default: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(12));
      2: return 31'($urandom_range(1000));
      default: return 31'($urandom_range(65535));
    endcase
  endfunction

  task automatic test_directed();
    logic [2:0] op;
    for (int i = 0; i <= OP_SPLIT; i++) begin
      op = 3'(i);
      send_fraction(op, 32'sh7fffffff, 31'h7fffffff, 32'sh80000000, 31'd1);
    end
    send_fraction(OP_ADD, 32'sd0, 31'd5, 32'sd0, 31'd7);
    send_fraction(OP_SUB, 32'sd3, 31'd4, 32'sd3, 31'd4);
    send_fraction(OP_ADD, 32'sd1, 31'd0, 32'sd1, 31'd2);
    send_fraction(OP_MUL, 32'sd1, 31'd2, 32'sd1, 31'd0);
    send_fraction(OP_SPLIT, 32'sd7, 31'd2, 32'sd1, 31'd0);
    send_fraction(OP_SPLIT, -32'sd7, 31'd0, 32'sd1, 31'd3);
    send_fraction(OP_DIV, 32'sd5, 31'd3, 32'sd0, 31'd9);
    send_fraction(OP_DIV, -32'sd5, 31'd3, -32'sd2, 31'd9);
    send_fraction(OP_MUL, 32'sh80000000, 31'd1, 32'sh80000000, 31'd1);
    send_fraction(OP_MUL, 32'sh80000000, 31'd1, 32'sd1, 31'd1);
    send_fraction(OP_SPLIT, 32'sh80000000, 31'd3, 32'sd0, 31'd1);
    send_fraction(OP_CMP, 32'sd2, 31'd4, 32'sd1, 31'd2);
    send_fraction(OP_CMP, 32'sd1, 31'd3, 32'sd1, 31'd2);
    send_fraction(OP_SUB, 32'sh80000000, 31'd1, 32'sd1, 31'd1);
    send_fraction(3'd6, 32'sd1, 31'd1, 32'sd1, 31'd1);
    send_fraction(3'd7, 32'sd0, 31'd0, 32'sd0, 31'd0);
    send_fraction(OP_ADD, 32'sh7fffffff, 31'h7fffffff, 32'sh7fffffff, 31'h7ffffffe);
  endtask

  task automatic test_random(int count);
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
      send_fraction(op, rand_num(), rand_den(), rand_num(), rand_den());
    end
  endtask

  // run limit
  initial begin
    #(64'd40_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = '0;
    in_a_num       = '0;
    in_a_den       = '0;
    in_b_num       = '0;
    in_b_den       = '0;
    out_ready      = 1'b0;
    mismatch_cnt   = 0;
    result_cnt     = 0;
    sent_cnt       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(200);
    send_idle_pct = 49;
    test_random(200);
    send_idle_pct  = 0;
    recv_stall_pct = 49;
    test_random(200);
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    test_random(200);
    in_valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("sent %0d fraction transactions over all ops, zero denominators and extremes",
             sent_cnt);
    $display("checked %0d results, %0d mismatches", result_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
